[rtl/birm_pkg.sv]
// Shared types and constants of the beat interval rate meter.
`default_nettype none

package birm_pkg;

    // Averaging window and interval counter width.
    localparam int SAMPLE_COUNT  = 10;
    localparam int INTERVAL_BITS = 24;
    localparam int SLOT_BITS     = $clog2(SAMPLE_COUNT);
    localparam int SUM_BITS      = INTERVAL_BITS + $clog2(SAMPLE_COUNT);

    // Register and result widths.
    localparam int NUM_BITS       = 24;
    localparam int LIMIT_BITS     = 10;
    localparam int RATE_BITS      = 10;
    localparam int DIGIT_BITS     = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STEP_BITS      = $clog2(NUM_BITS);

    // Interval queue between front and back.
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [INTERVAL_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SLOT_BITS-1:0]     LAST_SLOT = SLOT_BITS'(SAMPLE_COUNT - 1);
    localparam logic [RATE_BITS-1:0]     RATE_MAX  = 10'd999;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_NUMERATOR  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_RATE_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_RATE_LIMIT = 2'd2;

    // Register reset values.
    localparam logic [NUM_BITS-1:0]   RESET_NUMERATOR = 24'd2343750;
    localparam logic [LIMIT_BITS-1:0] RESET_LOW_LIMIT  = 10'd70;
    localparam logic [LIMIT_BITS-1:0] RESET_HIGH_LIMIT = 10'd160;

    // Decimal split by reciprocal multiplication, exact for rates up to 999.
    localparam int HUND_PROD_BITS = 16;
    localparam int HUND_RECIP     = 41;
    localparam int HUND_SHIFT     = 12;
    localparam int REM100_BITS    = 7;
    localparam int TENS_PROD_BITS = 15;
    localparam int TENS_RECIP     = 205;
    localparam int TENS_SHIFT     = 11;
    localparam int DEC_HUNDRED    = 100;
    localparam int DEC_TEN        = 10;

    // Queue fill status seen by both of its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // One finished result.
    typedef struct packed {
        logic                  stable;
        logic [DIGIT_BITS-1:0] ones;
        logic [DIGIT_BITS-1:0] tens;
        logic [DIGIT_BITS-1:0] hundreds;
        logic [RATE_BITS-1:0]  rate;
    } t_rate_result;

    // Sequencer of the rate unit.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLAMP,
        ST_HUND,
        ST_REM,
        ST_TENS,
        ST_ONES,
        ST_EMIT
    } t_back_state;

endpackage

`default_nettype wire

[rtl/birm_front.sv]
// Front part: counts ticks, keeps the interval ring and its running sum.
`default_nettype none

module birm_front import birm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_tick,
    input  wire logic                i_beat,
    input  wire t_fifo_stat          i_fifo_stat,
    output logic                     o_ready,
    output logic                     o_push,
    output logic [SUM_BITS-1:0]      o_push_sum
);

    logic [INTERVAL_BITS-1:0] r_count;
    logic [INTERVAL_BITS-1:0] n_count;
    logic [INTERVAL_BITS-1:0] r_ring [SAMPLE_COUNT];
    logic [SLOT_BITS-1:0]     r_slot;
    logic [SLOT_BITS-1:0]     n_slot;
    logic [SUM_BITS-1:0]      r_sum;
    logic [SUM_BITS-1:0]      n_sum;
    logic [INTERVAL_BITS-1:0] w_count_inc;
    logic                     w_accept;

    // A request is taken whenever the queue can hold a possible interval.
    assign o_ready  = !i_fifo_stat.full;
    assign w_accept = i_valid && o_ready;

    // The tick of a slot counts before its beat; the counter saturates.
    always_comb begin
        w_count_inc = (i_tick && (r_count != COUNT_MAX)) ? r_count + 1'b1 : r_count;
        n_sum       = r_sum - SUM_BITS'(r_ring[r_slot]) + SUM_BITS'(w_count_inc);
        n_slot      = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        n_count     = i_beat ? '0 : w_count_inc;
    end

    assign o_push     = w_accept && i_beat;
    assign o_push_sum = n_sum;

    // Counter, ring, slot and sum registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= '0;
            r_sum   <= '0;
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                r_ring[i] <= '0;
            end
        end else if (w_accept) begin
            r_count <= n_count;
            if (i_beat) begin
                r_ring[r_slot] <= w_count_inc;
                r_slot         <= n_slot;
                r_sum          <= n_sum;
            end
        end
    end

`ifndef SYNTHESIS
    // The write slot never leaves the ring.
    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("write slot outside the ring");
`endif

endmodule

`default_nettype wire

[rtl/birm_fifo.sv]
// Short queue of interval sums between the front and the rate unit.
`default_nettype none

module birm_fifo import birm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [SUM_BITS-1:0] i_push_sum,
    input  wire logic                i_pop,
    output t_fifo_stat               o_stat,
    output logic [SUM_BITS-1:0]      o_pop_sum
);

    logic [SUM_BITS-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    assign o_stat.full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_pop_sum    = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_sum;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Neither side works past the queue's limits.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_stat.full))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

[rtl/birm_back.sv]
// Back part: serial divide, clamp, decimal split and output register.
`default_nettype none

module birm_back import birm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_fifo_stat            i_fifo_stat,
    input  wire logic [SUM_BITS-1:0]   i_pop_sum,
    input  wire logic [NUM_BITS-1:0]   i_numerator,
    input  wire logic [LIMIT_BITS-1:0] i_low_limit,
    input  wire logic [LIMIT_BITS-1:0] i_high_limit,
    input  wire logic                  i_ready,
    output logic                       o_pop,
    output logic                       o_valid,
    output t_rate_result               o_result
);

    t_back_state               r_state;
    t_back_state               n_state;
    logic [SUM_BITS-1:0]       r_divisor;
    logic [SUM_BITS-1:0]       n_divisor;
    logic [SUM_BITS-1:0]       r_rem;
    logic [SUM_BITS-1:0]       n_rem;
    logic [NUM_BITS-1:0]       r_quo;
    logic [NUM_BITS-1:0]       n_quo;
    logic [STEP_BITS-1:0]      r_step;
    logic [STEP_BITS-1:0]      n_step;
    logic [RATE_BITS-1:0]      r_rate;
    logic [RATE_BITS-1:0]      n_rate;
    logic [DIGIT_BITS-1:0]     r_hund;
    logic [DIGIT_BITS-1:0]     n_hund;
    logic [DIGIT_BITS-1:0]     r_tens;
    logic [DIGIT_BITS-1:0]     n_tens;
    logic [DIGIT_BITS-1:0]     r_ones;
    logic [DIGIT_BITS-1:0]     n_ones;
    logic [REM100_BITS-1:0]    r_rem100;
    logic [REM100_BITS-1:0]    n_rem100;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_rate_result              r_out;
    t_rate_result              n_out;
    logic [SUM_BITS:0]         w_trial;
    logic [SUM_BITS:0]         w_diff;
    logic                      w_ge;
    logic [HUND_PROD_BITS-1:0] w_hund_prod;
    logic [TENS_PROD_BITS-1:0] w_tens_prod;

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // One restoring step: bring down the next numerator bit and try the divisor.
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_BITS-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_ge    = (w_trial >= {1'b0, r_divisor});
    end

    // Reciprocal products for the hundreds and tens digits.
    always_comb begin
        w_hund_prod = HUND_PROD_BITS'(r_rate) * HUND_PROD_BITS'(HUND_RECIP);
        w_tens_prod = TENS_PROD_BITS'(r_rem100) * TENS_PROD_BITS'(TENS_RECIP);
    end

    // Sequencer: next state and data path.
    always_comb begin
        n_state     = r_state;
        n_divisor   = r_divisor;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_rate      = r_rate;
        n_hund      = r_hund;
        n_tens      = r_tens;
        n_ones      = r_ones;
        n_rem100    = r_rem100;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    o_pop     = 1'b1;
                    n_divisor = i_pop_sum;
                    n_rem     = '0;
                    n_step    = STEP_BITS'(NUM_BITS - 1);
                    // An empty window reads as the top rate.
                    if (i_pop_sum == '0) begin
                        n_quo   = NUM_BITS'(RATE_MAX);
                        n_state = ST_CLAMP;
                    end else begin
                        n_quo   = i_numerator;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem  = w_ge ? w_diff[SUM_BITS-1:0] : w_trial[SUM_BITS-1:0];
                n_quo  = {r_quo[NUM_BITS-2:0], w_ge};
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                n_rate  = (r_quo > NUM_BITS'(RATE_MAX)) ? RATE_MAX : r_quo[RATE_BITS-1:0];
                n_state = ST_HUND;
            end
            ST_HUND: begin
                n_hund  = w_hund_prod[HUND_SHIFT +: DIGIT_BITS];
                n_state = ST_REM;
            end
            ST_REM: begin
                n_rem100 = REM100_BITS'(r_rate
                    - RATE_BITS'(r_hund) * RATE_BITS'(DEC_HUNDRED));
                n_state  = ST_TENS;
            end
            ST_TENS: begin
                n_tens  = w_tens_prod[TENS_SHIFT +: DIGIT_BITS];
                n_state = ST_ONES;
            end
            ST_ONES: begin
                n_ones  = DIGIT_BITS'(r_rem100
                    - REM100_BITS'(r_tens) * REM100_BITS'(DEC_TEN));
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out.rate     = r_rate;
                    n_out.hundreds = r_hund;
                    n_out.tens     = r_tens;
                    n_out.ones     = r_ones;
                    n_out.stable   = (r_rate >= i_low_limit) && (r_rate <= i_high_limit);
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_rate    <= n_rate;
        r_hund    <= n_hund;
        r_tens    <= n_tens;
        r_ones    <= n_ones;
        r_rem100  <= n_rem100;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    // A shown rate stays in range and its digits spell it.
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.rate <= RATE_MAX))
        else $error("rate above its clamp");
    a_digits_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.rate == RATE_BITS'(r_out.hundreds) * RATE_BITS'(DEC_HUNDRED)
            + RATE_BITS'(r_out.tens) * RATE_BITS'(DEC_TEN) + RATE_BITS'(r_out.ones)))
        else $error("digits do not match the rate");
    // The divider never runs on an empty window.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_divisor != '0))
        else $error("divide by zero");
`endif

endmodule

`default_nettype wire

[rtl/beat_interval_rate_meter.sv]
// Top level of the beat interval rate meter: registers, queue and the two parts.
//
// Input stream: one request per event slot, tdata bit 0 = timer tick,
// bit 1 = beat edge. Slots are taken one per cycle while the interval
// queue has room; a slot without a beat produces nothing.
// Output stream: one result per beat with the averaged rate over the last
// ten intervals, its three decimal digits and an in-range flag.
// Configuration: writes of register index and data, always ready; the
// numerator and the two rate limits are used by the next beats.
// Processing: the rate unit pops a beat's window sum from the queue,
// divides the numerator by a nonzero sum in the bit-serial divider, then
// clamps the quotient, splits it into decimal digits and loads the output register.
// The shared divider takes a new sum only after the last result is loaded;
// two beats can wait in the queue before the input stalls.
// Stalls: a result waits in the output register; the rate unit holds the
// next finished result until it is taken, and the queue then fills.
// Reset: synchronous, active low; clears the counter, ring, sum, queue and
// the output, and loads the register defaults.
`default_nettype none

module beat_interval_rate_meter import birm_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input slots.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,  // [0] tick, [1] beat, rest zero
    // Results.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // [9:0] rate_bpm,
                                                          // [13:10] digit_hundreds,
                                                          // [17:14] digit_tens,
                                                          // [21:18] digit_ones,
                                                          // [22] stable, [23] zero
    // Configuration writes.
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [NUM_BITS-1:0]       i_cfg_data
);

    logic [NUM_BITS-1:0]   r_numerator;
    logic [LIMIT_BITS-1:0] r_low_limit;
    logic [LIMIT_BITS-1:0] r_high_limit;
    t_fifo_stat            w_fifo_stat;
    logic                  w_push;
    logic [SUM_BITS-1:0]   w_push_sum;
    logic                  w_pop;
    logic [SUM_BITS-1:0]   w_pop_sum;
    t_rate_result          w_result;

    // Configuration registers; an unknown index is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numerator  <= RESET_NUMERATOR;
            r_low_limit  <= RESET_LOW_LIMIT;
            r_high_limit <= RESET_HIGH_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RATE_NUMERATOR:  r_numerator  <= i_cfg_data;
                CFG_LOW_RATE_LIMIT:  r_low_limit  <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_HIGH_RATE_LIMIT: r_high_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default:             r_numerator  <= r_numerator;
            endcase
        end
    end

    // Interval front end.
    birm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_tick      (s_axis_tdata[0]),
        .i_beat      (s_axis_tdata[1]),
        .i_fifo_stat (w_fifo_stat),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_push_sum  (w_push_sum)
    );

    // Queue of window sums.
    birm_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_sum (w_push_sum),
        .i_pop      (w_pop),
        .o_stat     (w_fifo_stat),
        .o_pop_sum  (w_pop_sum)
    );

    // Rate unit.
    birm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_stat  (w_fifo_stat),
        .i_pop_sum    (w_pop_sum),
        .i_numerator  (r_numerator),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .i_ready      (m_axis_tready),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .o_result     (w_result)
    );

    // Result packing, first field in the lowest bits.
    assign m_axis_tdata = {1'b0, w_result.stable, w_result.ones, w_result.tens,
                           w_result.hundreds, w_result.rate};

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the beat interval rate meter: a directed table, then random beat trains.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import birm_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 75;
    localparam int PLAN_LEN      = 29;
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ROW_SLOT,
        ROW_REG
    } t_row_kind;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    // One line of the directed plan: an event slot or a register write.
    typedef struct packed {
        t_row_kind                 kind;
        logic                      tick;
        logic                      beat;
        logic                      fixed;
        t_rate_result              want;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [NUM_BITS-1:0]       data;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;   // [0] tick, [1] beat, rest zero
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [23:0]               m_axis_tdata;        // [9:0] rate_bpm, [13:10] digit_hundreds,
                                                    // [17:14] digit_tens, [21:18] digit_ones,
                                                    // [22] stable, [23] zero
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [NUM_BITS-1:0]       i_cfg_data = '0;

    // Shadow of the meter: register copies and the interval history.
    logic [NUM_BITS-1:0]      num_mirror = RESET_NUMERATOR;
    logic [LIMIT_BITS-1:0]    lo_mirror = RESET_LOW_LIMIT;
    logic [LIMIT_BITS-1:0]    hi_mirror = RESET_HIGH_LIMIT;
    logic [INTERVAL_BITS-1:0] tick_tally = '0;
    logic [INTERVAL_BITS-1:0] span_hist [SAMPLE_COUNT];
    logic [SLOT_BITS-1:0]     hist_ptr = '0;
    logic [SUM_BITS-1:0]      span_total = '0;

    t_rate_result rate_expect_q [$];
    int           err_count = 0;

    // Sender pacing state.
    bit tx_on = 1'b0;
    int gap_max = 4;
    int burst_left = 1;

    // Receiver pacing state.
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_hold = 0;

    t_dir_row plan [PLAN_LEN];

    beat_interval_rate_meter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one event slot to the shadow; a beat yields the expected result.
    task automatic account_slot(input bit tick, input bit beat,
                                output bit fired, output t_rate_result res);
        logic [SUM_BITS-1:0] quot;
        int unsigned         rv;
        fired = 1'b0;
        res = '0;
        if (tick && tick_tally != COUNT_MAX)
            tick_tally = tick_tally + 1'b1;
        if (beat) begin
            span_total = span_total - span_hist[hist_ptr] + tick_tally;
            span_hist[hist_ptr] = tick_tally;
            hist_ptr = (hist_ptr == LAST_SLOT) ? '0 : hist_ptr + 1'b1;
            tick_tally = '0;
            if (span_total == '0)
                quot = SUM_BITS'(RATE_MAX);
            else
                quot = SUM_BITS'(num_mirror) / span_total;
            if (quot > SUM_BITS'(RATE_MAX))
                quot = SUM_BITS'(RATE_MAX);
            rv = quot;
            res.rate = RATE_BITS'(rv);
            res.hundreds = DIGIT_BITS'(rv / 100);
            res.tens = DIGIT_BITS'((rv / 10) % 10);
            res.ones = DIGIT_BITS'(rv % 10);
            res.stable = (res.rate >= lo_mirror) && (res.rate <= hi_mirror);
            fired = 1'b1;
        end
    endtask

    // Wait until every expected result has been taken, then let the pipeline settle.
    task automatic drain_results();
        while (rate_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        if (tx_on) begin
            s_axis_tvalid <= 1'b0;
            tx_on = 1'b0;
        end
    endtask

    // Offer one slot request; on acceptance, update the shadow and pace the next one.
    task automatic send_slot(input bit tick, input bit beat, input bit fixed,
                             input t_rate_result want);
        bit           fired;
        t_rate_result res;
        if (!tx_on) begin
            s_axis_tvalid <= 1'b1;
            tx_on = 1'b1;
        end
        s_axis_tdata <= {6'b0, beat, tick};
        do @(posedge i_clk); while (!s_axis_tready);
        account_slot(tick, beat, fired, res);
        if (fired)
            rate_expect_q.push_back(fixed ? want : res);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0) begin
                stop_sending();
                if ($urandom_range(0, 15) == 0)
                    drain_results();
                else
                    repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    // One register write; valid stays high so that writes can follow back to back.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [NUM_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RATE_NUMERATOR:  num_mirror = data;
            CFG_LOW_RATE_LIMIT:  lo_mirror = data[LIMIT_BITS-1:0];
            CFG_HIGH_RATE_LIMIT: hi_mirror = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    function automatic t_dir_row slot_row(bit tick, bit beat);
        t_dir_row r;
        r = '0;
        r.kind = ROW_SLOT;
        r.tick = tick;
        r.beat = beat;
        return r;
    endfunction

    function automatic t_dir_row fixed_row(bit tick, bit beat, int rate, int hund, int tens,
                                           int ones, bit stable);
        t_dir_row r;
        r = slot_row(tick, beat);
        r.fixed = 1'b1;
        r.want.rate = RATE_BITS'(rate);
        r.want.hundreds = DIGIT_BITS'(hund);
        r.want.tens = DIGIT_BITS'(tens);
        r.want.ones = DIGIT_BITS'(ones);
        r.want.stable = stable;
        return r;
    endfunction

    function automatic t_dir_row reg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [NUM_BITS-1:0] data);
        t_dir_row r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // Result readiness switches at random among open, coin-flip and sparse patterns.
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_hold <= $urandom_range(16, 96);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge i_clk) begin : rate_monitor
        t_rate_result got;
        t_rate_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[22:0];
            if (rate_expect_q.size() == 0) begin
                err_count++;
                $display("%0t ns: result with none expected, rate %0d", $time, got.rate);
            end else begin
                want = rate_expect_q.pop_front();
                check_field("rate_bpm", want.rate, got.rate);
                check_field("digit_hundreds", want.hundreds, got.hundreds);
                check_field("digit_tens", want.tens, got.tens);
                check_field("digit_ones", want.ones, got.ones);
                check_field("stable", want.stable, got.stable);
                check_field("pad bit", 0, m_axis_tdata[23]);
            end
        end
    end

    // Stimulus: directed plan, then phases of random beat trains under varied settings.
    initial begin
        bit                  cfg_busy;
        int                  sent;
        int                  span_mean;
        int                  n;
        int                  lo_pick;
        int                  hi_pick;
        int                  sum_est;
        logic [NUM_BITS-1:0] num_pick;

        for (int i = 0; i < SAMPLE_COUNT; i++)
            span_hist[i] = '0;
        cfg_busy = 1'b0;
        burst_left = $urandom_range(1, 24);

        plan = '{
            fixed_row(0, 1, 999, 9, 9, 9, 0),       // empty history
            slot_row(1, 0),
            fixed_row(1, 1, 999, 9, 9, 9, 0),       // short interval, clamped
            slot_row(0, 0),
            reg_row(CFG_RATE_NUMERATOR, 24'd0),
            fixed_row(1, 1, 0, 0, 0, 0, 0),         // zero numerator
            reg_row(CFG_LOW_RATE_LIMIT, 24'd0),
            fixed_row(0, 1, 0, 0, 0, 0, 1),
            reg_row(CFG_RATE_NUMERATOR, 24'hFFFFFF),
            reg_row(CFG_LOW_RATE_LIMIT, 24'hFFFC05), // upper bits dropped, keeps 5
            reg_row(CFG_HIGH_RATE_LIMIT, 24'hFFFFFF),
            fixed_row(0, 1, 999, 9, 9, 9, 1),
            reg_row(CFG_SPARE, 24'd0),               // must not touch any register
            fixed_row(0, 1, 999, 9, 9, 9, 1),
            reg_row(CFG_LOW_RATE_LIMIT, 24'd999),
            reg_row(CFG_HIGH_RATE_LIMIT, 24'd999),
            fixed_row(1, 1, 999, 9, 9, 9, 1),
            reg_row(CFG_RATE_NUMERATOR, 24'd3000),
            reg_row(CFG_LOW_RATE_LIMIT, 24'd500),    // limits crossed
            reg_row(CFG_HIGH_RATE_LIMIT, 24'd100),
            slot_row(1, 0),
            slot_row(1, 0),
            slot_row(1, 1),
            reg_row(CFG_LOW_RATE_LIMIT, 24'd400),
            reg_row(CFG_HIGH_RATE_LIMIT, 24'd450),
            slot_row(0, 1),
            slot_row(1, 1),                          // these wrap the history
            slot_row(1, 1),
            slot_row(1, 1)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plan.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_REG) begin
                if (!cfg_busy) begin
                    stop_sending();
                    drain_results();
                end
                cfg_write(plan[i].idx, plan[i].data);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) begin
                    i_cfg_valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                send_slot(plan[i].tick, plan[i].beat, plan[i].fixed, plan[i].want);
            end
        end

        // Random phases.
        for (int phase = 0; phase < PHASES; phase++) begin
            stop_sending();
            drain_results();

            span_mean = $urandom_range(0, 10);
            sum_est = SAMPLE_COUNT * (span_mean + 1);
            case ($urandom_range(0, 7))
                0:       num_pick = 24'hFFFFFF;
                1:       num_pick = 24'd0;
                2:       num_pick = NUM_BITS'($urandom);
                default: num_pick = NUM_BITS'(sum_est * $urandom_range(40, 300));
            endcase
            case ($urandom_range(0, 5))
                0: begin
                    lo_pick = 0;
                    hi_pick = $urandom_range(999, 1023);
                end
                1: begin
                    lo_pick = $urandom_range(100, 999);
                    hi_pick = $urandom_range(0, lo_pick - 1);
                end
                2: begin
                    lo_pick = $urandom_range(0, 999);
                    hi_pick = lo_pick;
                end
                default: begin
                    lo_pick = $urandom_range(0, 300);
                    hi_pick = lo_pick + $urandom_range(0, 300);
                end
            endcase
            // Upper data bits are random; the limits keep only their low bits.
            cfg_write(CFG_RATE_NUMERATOR, num_pick);
            cfg_write(CFG_LOW_RATE_LIMIT,
                      NUM_BITS'(($urandom << LIMIT_BITS) | 32'(lo_pick)));
            if ($urandom_range(0, 1) == 0)
                cfg_write(CFG_SPARE, NUM_BITS'($urandom));
            cfg_write(CFG_HIGH_RATE_LIMIT,
                      NUM_BITS'(($urandom << LIMIT_BITS) | 32'(hi_pick)));
            i_cfg_valid <= 1'b0;

            // Every third phase streams without sender gaps.
            gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 10);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 6) != 0) begin
                    // A well-formed interval: ticks with idle slots between, then a beat.
                    n = span_mean + $urandom_range(0, 2);
                    for (int k = 0; k < n; k++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_slot(1'b0, 1'b0, 1'b0, '0);
                            sent++;
                        end
                        send_slot(1'b1, 1'b0, 1'b0, '0);
                        sent++;
                    end
                    send_slot(1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
                    sent++;
                end else begin
                    // Noise: any slot, including back-to-back beats.
                    send_slot(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
                    sent++;
                end
            end
        end

        stop_sending();
        drain_results();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
